/* hw/rtl/tpi_pkg.sv */
package tpi_pkg;

    // Coordinate format: signed Q16.8 in 24 bits.
    localparam int POS_W   = 24;
    localparam int HEAD_W  = 7;
    localparam int ENTRY_W = 2 * POS_W + HEAD_W;
    localparam int DELTA_W = 20;
    localparam int SINE_W  = 25;

    // Heading in steps of 5 degrees.
    localparam logic [HEAD_W-1:0] HEADING_STEPS = 7'd72;
    localparam logic [HEAD_W-1:0] HEADING_RESET = 7'd9;
    localparam logic [HEAD_W-1:0] TURN_STEPS    = 7'd5;
    localparam logic [HEAD_W-1:0] QUARTER_STEPS = 7'd18;

    // Symbols that act.
    localparam logic [7:0] SYM_MOVE = 8'h46;
    localparam logic [7:0] SYM_CW   = 8'h2B;
    localparam logic [7:0] SYM_CCW  = 8'h2D;
    localparam logic [7:0] SYM_PUSH = 8'h5B;
    localparam logic [7:0] SYM_POP  = 8'h5D;

    // Input kinds.
    localparam logic KIND_START  = 1'b0;
    localparam logic KIND_SYMBOL = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_STEP_LENGTH = 2'd0;
    localparam logic [1:0] CFG_START_X     = 2'd1;
    localparam logic [1:0] CFG_START_Y     = 2'd2;

    // Operations handed from the issue stage to the execute stage.
    localparam logic [2:0] OP_NOP    = 3'd0;
    localparam logic [2:0] OP_START  = 3'd1;
    localparam logic [2:0] OP_MOVE   = 3'd2;
    localparam logic [2:0] OP_CW     = 3'd3;
    localparam logic [2:0] OP_CCW    = 3'd4;
    localparam logic [2:0] OP_PUSH   = 3'd5;
    localparam logic [2:0] OP_POP    = 3'd6;
    localparam logic [2:0] OP_FAULT  = 3'd7;

    typedef struct packed {
        logic       valid;
        logic [2:0] op;
        logic       fwd;
    } tpi_ex_t;

    typedef struct packed {
        logic        [9:0]  step_length;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
    } tpi_cfg_t;

    // round(sin(k * 5 deg) * 2^24) for k = 0..18.
    function automatic logic [SINE_W-1:0] sine_quarter(input logic [4:0] k);
        logic [SINE_W-1:0] v;
        case (k)
            5'd0:    v = 25'd0;
            5'd1:    v = 25'd1462231;
            5'd2:    v = 25'd2913333;
            5'd3:    v = 25'd4342263;
            5'd4:    v = 25'd5738146;
            5'd5:    v = 25'd7090358;
            5'd6:    v = 25'd8388608;
            5'd7:    v = 25'd9623016;
            5'd8:    v = 25'd10784187;
            5'd9:    v = 25'd11863283;
            5'd10:   v = 25'd12852093;
            5'd11:   v = 25'd13743091;
            5'd12:   v = 25'd14529495;
            5'd13:   v = 25'd15205322;
            5'd14:   v = 25'd15765426;
            5'd15:   v = 25'd16205546;
            5'd16:   v = 25'd16522332;
            5'd17:   v = 25'd16713374;
            5'd18:   v = 25'd16777216;
            default: v = 25'd0;
        endcase
        return v;
    endfunction

    // Full-circle sine from the quarter table: returns {negative, magnitude}.
    function automatic logic [SINE_W:0] sine_full(input logic [HEAD_W-1:0] k);
        logic [HEAD_W-1:0] idx;
        logic              neg;
        if (k <= 7'd18) begin
            idx = k;
            neg = 1'b0;
        end else if (k <= 7'd36) begin
            idx = 7'd36 - k;
            neg = 1'b0;
        end else if (k <= 7'd54) begin
            idx = k - 7'd36;
            neg = 1'b1;
        end else begin
            idx = HEADING_STEPS - k;
            neg = 1'b1;
        end
        return {neg, sine_quarter(idx[4:0])};
    endfunction

    // Clamp a 25-bit signed sum to the signed 24-bit range.
    function automatic logic [POS_W-1:0] sat_pos(input logic signed [POS_W:0] v);
        logic [POS_W-1:0] r;
        if (v > 25'sd8388607) begin
            r = 24'h7FFFFF;
        end else if (v < -25'sd8388608) begin
            r = 24'h800000;
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

/* hw/rtl/tpi_ram.sv */
module tpi_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Single write port, registered read port returning old data on a collision.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/tpi_issue.sv */
module tpi_issue #(
    parameter int STACK_DEPTH = 64,
    parameter int ADDR_W      = $clog2(STACK_DEPTH),
    parameter int LVL_W       = $clog2(STACK_DEPTH + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic [0:0]        s_tuser,
    output tpi_pkg::tpi_ex_t  ex,
    output logic [ADDR_W-1:0] ex_addr,
    input  logic              ex_ready,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr
);

    import tpi_pkg::*;

    tpi_ex_t           ex_reg, ex_next;
    logic [ADDR_W-1:0] ex_addr_reg, ex_addr_next;
    logic [LVL_W-1:0]  level_reg, level_next;
    logic              accept;
    logic [2:0]        op;
    logic [LVL_W-1:0]  level_dec;

    assign s_tready  = !ex_reg.valid || ex_ready;
    assign accept    = s_tvalid && s_tready;
    assign level_dec = level_reg - LVL_W'(1);

    // Decode the request and track the stack level ahead of the execute stage.
    always_comb begin
        op           = OP_NOP;
        level_next   = level_reg;
        ex_addr_next = ex_addr_reg;
        if (s_tuser[0] == KIND_START) begin
            op         = OP_START;
            level_next = '0;
        end else begin
            case (s_tdata)
                SYM_MOVE: op = OP_MOVE;
                SYM_CW:   op = OP_CW;
                SYM_CCW:  op = OP_CCW;
                SYM_PUSH: begin
                    if (level_reg == LVL_W'(STACK_DEPTH)) begin
                        op = OP_FAULT;
                    end else begin
                        op           = OP_PUSH;
                        ex_addr_next = level_reg[ADDR_W-1:0];
                        level_next   = level_reg + LVL_W'(1);
                    end
                end
                SYM_POP: begin
                    if (level_reg == '0) begin
                        op = OP_FAULT;
                    end else begin
                        op           = OP_POP;
                        ex_addr_next = level_dec[ADDR_W-1:0];
                        level_next   = level_dec;
                    end
                end
                default: op = OP_NOP;
            endcase
        end
    end

    // A pop right behind a push reads the entry the push writes in the same cycle.
    always_comb begin
        ex_next = ex_reg;
        if (accept) begin
            ex_next.valid = 1'b1;
            ex_next.op    = op;
            ex_next.fwd   = ex_reg.valid && (ex_reg.op == OP_PUSH) && ex_ready;
        end else if (ex_ready) begin
            ex_next.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_reg    <= '0;
            level_reg <= '0;
        end else begin
            ex_reg <= ex_next;
            if (accept) begin
                level_reg <= level_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ex_addr_reg <= ex_addr_next;
        end
    end

    assign rd_en   = accept && (op == OP_POP);
    assign rd_addr = ex_addr_next;
    assign ex      = ex_reg;
    assign ex_addr = ex_addr_reg;

endmodule

/* hw/rtl/tpi_exec.sv */
module tpi_exec #(
    parameter int STACK_DEPTH    = 64,
    parameter int TRIG_FRAC_BITS = 15,
    parameter int ADDR_W         = $clog2(STACK_DEPTH)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  tpi_pkg::tpi_cfg_t            cfg,
    input  tpi_pkg::tpi_ex_t             ex,
    input  logic [ADDR_W-1:0]            ex_addr,
    output logic                         ex_ready,
    output logic                         wr_en,
    output logic [ADDR_W-1:0]            wr_addr,
    output logic [tpi_pkg::ENTRY_W-1:0]  wr_data,
    input  logic [tpi_pkg::ENTRY_W-1:0]  rd_data,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [47:0]                  m_tdata,
    output logic [1:0]                   m_tuser
);

    import tpi_pkg::*;

    // Trig value width and rounding constants.
    localparam int TW            = TRIG_FRAC_BITS + 1;
    localparam int TSH           = 24 - TRIG_FRAC_BITS;
    localparam logic [SINE_W-1:0] THALF = SINE_W'((1 << TSH) >> 1);
    localparam int PW            = 10 + TW;
    localparam int MSH           = TRIG_FRAC_BITS - 8;
    localparam logic [PW-1:0] MHALF = PW'((1 << MSH) >> 1);

    logic [POS_W-1:0]   x_reg, x_next;
    logic [POS_W-1:0]   y_reg, y_next;
    logic [HEAD_W-1:0]  h_reg, h_next;
    logic [ENTRY_W-1:0] last_push_reg;
    logic               m_valid_reg;
    logic [POS_W-1:0]   out_x_reg, out_y_reg;
    logic               out_new_reg, out_fault_reg;

    logic               produces, fire;
    logic               emit_new, emit_fault;
    logic [HEAD_W-1:0]  cos_idx, pop_h;
    logic [ENTRY_W-1:0] entry;
    logic [TW:0]        trig_c, trig_s;
    logic signed [DELTA_W-1:0] dx, dy;
    logic signed [POS_W:0]     sum_x, sum_y;

    // Sine of a heading index in TRIG_FRAC_BITS format: {negative, magnitude}.
    function automatic logic [TW:0] trig(input logic [HEAD_W-1:0] k);
        logic [SINE_W:0]   raw;
        logic [SINE_W-1:0] rnd;
        logic [TW-1:0]     mag;
        raw = sine_full(k);
        rnd = (raw[SINE_W-1:0] + THALF) >> TSH;
        mag = rnd[TW-1:0];
        return {raw[SINE_W] && (mag != '0), mag};
    endfunction

    // Step length times trig value in Q.8, rounded half away from zero.
    function automatic logic signed [DELTA_W-1:0] move(input logic [9:0] len,
                                                       input logic [TW:0] tr);
        logic [PW-1:0]      prod;
        logic [PW-1:0]      rnd;
        logic [DELTA_W-1:0] mag;
        prod = PW'(len) * PW'(tr[TW-1:0]);
        rnd  = (prod + MHALF) >> MSH;
        mag  = {1'b0, rnd[DELTA_W-2:0]};
        return tr[TW] ? -$signed(mag) : $signed(mag);
    endfunction

    assign produces = (ex.op == OP_START) || (ex.op == OP_MOVE) ||
                      (ex.op == OP_POP) || (ex.op == OP_FAULT);
    assign ex_ready = !ex.valid || !produces || !m_valid_reg || m_tready;
    assign fire     = ex.valid && ex_ready;

    // Move deltas from the current heading.
    always_comb begin
        cos_idx = (h_reg >= HEADING_STEPS - QUARTER_STEPS) ?
                  h_reg - (HEADING_STEPS - QUARTER_STEPS) : h_reg + QUARTER_STEPS;
        trig_c  = trig(cos_idx);
        trig_s  = trig(h_reg);
        dx      = move(cfg.step_length, trig_c);
        dy      = move(cfg.step_length, trig_s);
        sum_x   = $signed({x_reg[POS_W-1], x_reg}) + (POS_W + 1)'(dx);
        sum_y   = $signed({y_reg[POS_W-1], y_reg}) - (POS_W + 1)'(dy);
    end

    // Restored entry, taken from the bypass when the push has only just been written.
    always_comb begin
        entry = ex.fwd ? last_push_reg : rd_data;
        pop_h = entry[ENTRY_W-1 -: HEAD_W];
        if (pop_h >= HEADING_STEPS) begin
            pop_h = pop_h - HEADING_STEPS;
        end
    end

    // Turtle update for each operation.
    always_comb begin
        x_next     = x_reg;
        y_next     = y_reg;
        h_next     = h_reg;
        emit_new   = 1'b0;
        emit_fault = 1'b0;
        case (ex.op)
            OP_START: begin
                x_next   = {cfg.start_x, 8'h00};
                y_next   = {cfg.start_y, 8'h00};
                h_next   = HEADING_RESET;
                emit_new = 1'b1;
            end
            OP_MOVE: begin
                x_next = sat_pos(sum_x);
                y_next = sat_pos(sum_y);
            end
            OP_CW: begin
                h_next = (h_reg >= TURN_STEPS) ? h_reg - TURN_STEPS :
                         h_reg + (HEADING_STEPS - TURN_STEPS);
            end
            OP_CCW: begin
                h_next = (h_reg >= HEADING_STEPS - TURN_STEPS) ?
                         h_reg - (HEADING_STEPS - TURN_STEPS) : h_reg + TURN_STEPS;
            end
            OP_POP: begin
                x_next   = entry[POS_W-1:0];
                y_next   = entry[2*POS_W-1:POS_W];
                h_next   = pop_h;
                emit_new = 1'b1;
            end
            OP_FAULT: emit_fault = 1'b1;
            default: begin
            end
        endcase
    end

    assign wr_en   = fire && (ex.op == OP_PUSH);
    assign wr_addr = ex_addr;
    assign wr_data = {h_reg, y_reg, x_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg       <= '0;
            y_reg       <= '0;
            h_reg       <= HEADING_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                x_reg <= x_next;
                y_reg <= y_next;
                h_reg <= h_next;
            end
            if (fire && produces) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result register and push bypass.
    always_ff @(posedge aclk) begin
        if (fire && produces) begin
            out_x_reg     <= x_next;
            out_y_reg     <= y_next;
            out_new_reg   <= emit_new;
            out_fault_reg <= emit_fault;
        end
        if (wr_en) begin
            last_push_reg <= wr_data;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_y_reg, out_x_reg};
    assign m_tuser  = {out_fault_reg, out_new_reg};

endmodule

/* hw/rtl/turtle_path_interpreter.sv */
// Turtle path interpreter: takes one request per clock, a start request (tuser
// kind 0) or an L-system symbol (kind 1), and returns at most one point per
// request, presented on m_tvalid from the result register: the accepting
// cycle decodes the request and issues the branch stack read, and the
// execute stage then updates the turtle and loads the result register.
// Back-to-back symbols, including a pop right after a push, run at one per
// clock; the rate drops only while a finished point waits on m_tready. The
// branch stack is a STACK_DEPTH-entry RAM holding position and heading;
// entries are never cleared, since only pushed entries are read. Write the
// configuration registers only while no request is in flight.
module turtle_path_interpreter #(
    parameter int STACK_DEPTH    = 64,
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Symbol channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] symbol
    input  logic [0:0]  s_tuser,   // [0] kind
    // Point channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [23:0] point_x, [47:24] point_y
    output logic [1:0]  m_tuser,   // [0] starts_new_set, [1] stack_fault
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    import tpi_pkg::*;

    localparam int ADDR_W = $clog2(STACK_DEPTH);

    tpi_cfg_t           cfg_reg;
    tpi_ex_t            ex;
    logic [ADDR_W-1:0]  ex_addr;
    logic               ex_ready;
    logic               rd_en, wr_en;
    logic [ADDR_W-1:0]  rd_addr, wr_addr;
    logic [ENTRY_W-1:0] rd_data, wr_data;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_length <= 10'd70;
            cfg_reg.start_x     <= '0;
            cfg_reg.start_y     <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_STEP_LENGTH: cfg_reg.step_length <= cfg_data[9:0];
                CFG_START_X:     cfg_reg.start_x     <= cfg_data;
                CFG_START_Y:     cfg_reg.start_y     <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    tpi_issue #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_issue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .ex       (ex),
        .ex_addr  (ex_addr),
        .ex_ready (ex_ready),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr)
    );

    tpi_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tpi_exec #(
        .STACK_DEPTH    (STACK_DEPTH),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_exec (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .ex       (ex),
        .ex_addr  (ex_addr),
        .ex_ready (ex_ready),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_data  (rd_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
